>>> hw/rtl/hcfv_pkg.sv
`timescale 1ns / 1ps

package hcfv_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned LEN_W    = COUNT_W + 1;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // Longest frame that passes the length check.
    localparam logic [LEN_W-1:0] MAX_FRAME_BYTES = LEN_W'(255);
    localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = LEN_W'(4);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Byte positions within a frame.
    localparam logic [COUNT_W-1:0] POS_HEAD   = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] POS_LENGTH = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_ADDR   = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] POS_CMD    = COUNT_W'(4);

    localparam logic [CFG_IDX_W-1:0] REG_HEAD_VALUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_VALUE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_HEAD = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_TAIL = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LEN  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SUM  = 3'd4;

    localparam logic [BYTE_W-1:0] ASCII_ZERO       = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_BASE = 8'h37;

    // Uppercase ASCII hex digit for a nibble.
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
        begin
            hex_char = ASCII_ZERO + wide;
        end
        else
        begin
            hex_char = ASCII_UPPER_BASE + wide;
        end
    endfunction

endpackage

>>> hw/rtl/hcfv_stream_if.sv
`timescale 1ns / 1ps

interface hcfv_byte_if;
    logic                             valid;
    logic                             ready;
    logic [hcfv_pkg::BYTE_W-1:0]      data_byte;
    logic                             end_of_frame;

    modport source (output valid, output data_byte, output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface hcfv_result_if;
    logic                             valid;
    logic                             ready;
    logic [hcfv_pkg::STATUS_W-1:0]    status;
    logic [hcfv_pkg::BYTE_W-1:0]      frame_addr;
    logic [hcfv_pkg::BYTE_W-1:0]      frame_cmd;

    modport source (output valid, output status, output frame_addr, output frame_cmd,
                    input ready);
    modport sink   (input valid, input status, input frame_addr, input frame_cmd,
                    output ready);
endinterface

>>> hw/rtl/hex_checksum_frame_validator.sv
`timescale 1ns / 1ps
// The frame status enters the result register in the cycle after the
// transaction that carries the end-of-frame byte; other bytes give no result.
// Throughput: one byte per cycle; the input stalls only while a result waits
// and the receiver is not ready, since the result register is the only stage.
// Reset (rst_n low, asynchronous) clears the frame state, both registers and
// the result valid flag.
module hex_checksum_frame_validator
#(
    parameter logic [hcfv_pkg::LEN_W-1:0] MAX_FRAME_BYTES = hcfv_pkg::MAX_FRAME_BYTES
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [hcfv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hcfv_pkg::BYTE_W-1:0]          cfg_data,
    hcfv_byte_if.sink                            byte_in,
    hcfv_result_if.source                        result
);

    logic [hcfv_pkg::BYTE_W-1:0]   head_value_reg;
    logic [hcfv_pkg::BYTE_W-1:0]   tail_value_reg;

    logic [hcfv_pkg::COUNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [hcfv_pkg::BYTE_W-1:0]   running_sum_reg, running_sum_next;
    logic                          head_ok_reg, head_ok_next;
    logic [hcfv_pkg::BYTE_W-1:0]   length_byte_reg, length_byte_next;
    logic [hcfv_pkg::BYTE_W-1:0]   addr_byte_reg, addr_byte_next;
    logic [hcfv_pkg::BYTE_W-1:0]   cmd_byte_reg, cmd_byte_next;
    logic [hcfv_pkg::BYTE_W-1:0]   prev_one_reg, prev_one_next;
    logic [hcfv_pkg::BYTE_W-1:0]   prev_two_reg, prev_two_next;

    logic                          out_valid_reg, out_valid_next;
    logic [hcfv_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [hcfv_pkg::BYTE_W-1:0]   frame_addr_reg, frame_addr_next;
    logic [hcfv_pkg::BYTE_W-1:0]   frame_cmd_reg, frame_cmd_next;

    logic                          in_accept;
    logic                          head_ok_cur;
    logic [hcfv_pkg::BYTE_W-1:0]   length_cur;
    logic [hcfv_pkg::BYTE_W-1:0]   addr_cur;
    logic [hcfv_pkg::BYTE_W-1:0]   cmd_cur;
    logic [hcfv_pkg::LEN_W-1:0]    frame_len;
    logic [hcfv_pkg::BYTE_W-1:0]   payload_sum;
    logic                          len_bad;
    logic                          sum_bad;
    logic [hcfv_pkg::STATUS_W-1:0] frame_status;

    assign byte_in.ready = !out_valid_reg || result.ready;
    assign in_accept     = byte_in.valid && byte_in.ready;

    assign result.valid      = out_valid_reg;
    assign result.status     = status_reg;
    assign result.frame_addr = frame_addr_reg;
    assign result.frame_cmd  = frame_cmd_reg;

    // Header fields as they stand once the current byte is taken into account.
    always_comb
    begin
        head_ok_cur = head_ok_reg;
        length_cur  = length_byte_reg;
        addr_cur    = addr_byte_reg;
        cmd_cur     = cmd_byte_reg;
        case (byte_count_reg)
            hcfv_pkg::POS_HEAD:   head_ok_cur = (byte_in.data_byte == head_value_reg);
            hcfv_pkg::POS_LENGTH: length_cur  = byte_in.data_byte;
            hcfv_pkg::POS_ADDR:   addr_cur    = byte_in.data_byte;
            hcfv_pkg::POS_CMD:    cmd_cur     = byte_in.data_byte;
            default:              ;
        endcase
    end

    // The running sum covers bytes 1 up to the one before the tail, so the two
    // checksum digits are taken back out of it.
    assign frame_len   = {1'b0, byte_count_reg} + hcfv_pkg::LEN_W'(1);
    assign payload_sum = running_sum_reg - prev_one_reg - prev_two_reg;
    assign len_bad     = (frame_len < hcfv_pkg::MIN_FRAME_BYTES)
                      || (frame_len > MAX_FRAME_BYTES)
                      || ({{(hcfv_pkg::LEN_W-hcfv_pkg::BYTE_W){1'b0}}, length_cur} != frame_len);
    assign sum_bad     = (prev_two_reg != hcfv_pkg::hex_char(payload_sum[7:4]))
                      || (prev_one_reg != hcfv_pkg::hex_char(payload_sum[3:0]));

    always_comb
    begin
        if (!head_ok_cur)
        begin
            frame_status = hcfv_pkg::STATUS_BAD_HEAD;
        end
        else if (byte_in.data_byte != tail_value_reg)
        begin
            frame_status = hcfv_pkg::STATUS_BAD_TAIL;
        end
        else if (len_bad)
        begin
            frame_status = hcfv_pkg::STATUS_BAD_LEN;
        end
        else if (sum_bad)
        begin
            frame_status = hcfv_pkg::STATUS_BAD_SUM;
        end
        else
        begin
            frame_status = hcfv_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        head_ok_next     = head_ok_reg;
        length_byte_next = length_byte_reg;
        addr_byte_next   = addr_byte_reg;
        cmd_byte_next    = cmd_byte_reg;
        prev_one_next    = prev_one_reg;
        prev_two_next    = prev_two_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        status_next      = status_reg;
        frame_addr_next  = frame_addr_reg;
        frame_cmd_next   = frame_cmd_reg;

        if (in_accept)
        begin
            if (byte_in.end_of_frame)
            begin
                out_valid_next   = 1'b1;
                status_next      = frame_status;
                frame_addr_next  = addr_cur;
                frame_cmd_next   = cmd_cur;
                byte_count_next  = '0;
                running_sum_next = '0;
                head_ok_next     = 1'b0;
                length_byte_next = '0;
                addr_byte_next   = '0;
                cmd_byte_next    = '0;
                prev_one_next    = '0;
                prev_two_next    = '0;
            end
            else
            begin
                head_ok_next     = head_ok_cur;
                length_byte_next = length_cur;
                addr_byte_next   = addr_cur;
                cmd_byte_next    = cmd_cur;
                if (byte_count_reg != hcfv_pkg::POS_HEAD)
                begin
                    running_sum_next = running_sum_reg + byte_in.data_byte;
                end
                prev_two_next = prev_one_reg;
                prev_one_next = byte_in.data_byte;
                if (byte_count_reg != hcfv_pkg::COUNT_MAX)
                begin
                    byte_count_next = byte_count_reg + hcfv_pkg::COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_value_reg <= '0;
            tail_value_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hcfv_pkg::REG_HEAD_VALUE: head_value_reg <= cfg_data;
                hcfv_pkg::REG_TAIL_VALUE: tail_value_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
            head_ok_reg     <= 1'b0;
            length_byte_reg <= '0;
            addr_byte_reg   <= '0;
            cmd_byte_reg    <= '0;
            prev_one_reg    <= '0;
            prev_two_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
            head_ok_reg     <= head_ok_next;
            length_byte_reg <= length_byte_next;
            addr_byte_reg   <= addr_byte_next;
            cmd_byte_reg    <= cmd_byte_next;
            prev_one_reg    <= prev_one_next;
            prev_two_reg    <= prev_two_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        frame_addr_reg <= frame_addr_next;
        frame_cmd_reg  <= frame_cmd_next;
    end

endmodule
